/* design/ggx_pkg.sv */
// ----------------------------------------------------------------------------
// ggx_pkg
// Shared constants of the GGX microfacet evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package ggx_pkg;

	localparam int QUO_W = 32;
	localparam int DIV_LAT = QUO_W + 1;
	localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
	localparam logic [14:0] ROUGH_RESET = 15'd16384;

endpackage

`default_nettype wire

/* design/ggx_div_pipe.sv */
// ----------------------------------------------------------------------------
// ggx_div_pipe
// Pipelined restoring divider, one quotient bit per stage, 32-bit saturating
// quotient. The pipeline advances only while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_div_pipe #(
	parameter int NUM_W = 77,
	parameter int DEN_W = 64
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [NUM_W-1:0]          num,
	input  wire logic [DEN_W-1:0]          den,
	output logic      [ggx_pkg::QUO_W-1:0] quo,
	output logic                           ovf
);

	localparam int QW = ggx_pkg::QUO_W;
	localparam int HI_W = NUM_W - QW;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [DEN_W-1:0] rem_s [0:QW];
	logic [QW-1:0]    lo_s  [0:QW];
	logic [DEN_W-1:0] den_s [0:QW];
	logic             ovf_s [0:QW];

	logic [CMP_W-1:0] hi_ext;
	logic [CMP_W-1:0] den_ext;
	logic             hi_ovf;
	logic [DEN_W:0]   t_c  [1:QW];
	logic             ge_c [1:QW];

	assign hi_ext = CMP_W'(num[NUM_W-1:QW]);
	assign den_ext = CMP_W'(den);
	assign hi_ovf = hi_ext >= den_ext;

	always_comb begin
		for (int k = 1; k <= QW; k++) begin
			t_c[k] = {rem_s[k-1], lo_s[k-1][QW-1]};
			ge_c[k] = t_c[k] >= {1'b0, den_s[k-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= hi_ovf ? '0 : DEN_W'(hi_ext);
			lo_s[0] <= num[QW-1:0];
			den_s[0] <= den;
			ovf_s[0] <= hi_ovf;
			for (int k = 1; k <= QW; k++) begin
				rem_s[k] <= ge_c[k] ? DEN_W'(t_c[k] - {1'b0, den_s[k-1]}) : DEN_W'(t_c[k]);
				lo_s[k] <= {lo_s[k-1][QW-2:0], ge_c[k]};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = ovf_s[QW] ? '1 : lo_s[QW];
	assign ovf = ovf_s[QW];

endmodule

`default_nettype wire

/* design/ggx_microfacet_eval_core.sv */
// ----------------------------------------------------------------------------
// ggx_microfacet_eval_core
// GGX distribution, masking, lambda and pdf for one direction pair per item.
// Throughput: one item per cycle; a stalled output freezes the pipe only
// when its last stage is occupied. Length set by two 31-step square roots
// and the 33-stage dividers. Reset clears all valids, roughness = 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_microfacet_eval_core #(
	parameter int COMPONENT_FRACTION_BITS = 15
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// dir_x, dir_y, dir_z, half_x, half_y, half_z
	input  wire logic [95:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// density, masking, lambda_term, probability
	output logic      [111:0] m_tdata,
	// clipped
	output logic              m_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [14:0]  cfg_data
);

	localparam int F = COMPONENT_FRACTION_BITS;
	localparam int SHL = (F <= 15) ? (30 - 2 * F) : 0;
	localparam int SHR = (F > 15) ? (2 * F - 30) : 0;
	localparam logic [23:0] LIM = 24'(1) << F;

	localparam int HSQ_STEPS = 16;
	localparam int WSQ_STEPS = 31;
	localparam int ST_W0 = 4;
	localparam int ST_WEND = ST_W0 + WSQ_STEPS - 1;
	localparam int ST_H0 = ST_WEND - HSQ_STEPS + 1;
	localparam int ST_MUL = ST_WEND + 1;
	localparam int ST_DEND = ST_MUL + ggx_pkg::DIV_LAT;
	localparam int ST_OUT = ST_DEND + 1;

	typedef struct packed {
		logic [61:0] rad;
		logic [32:0] rem;
		logic [30:0] root;
	} sqrt_t;

	typedef struct packed {
		logic gh;
		logic gw;
		logic back;
	} flags_t;

	function automatic sqrt_t sqrt_step(sqrt_t a);
		sqrt_t r;
		logic [34:0] t;
		logic [34:0] trial;
		t = {a.rem, a.rad[61:60]};
		trial = {2'b00, a.root, 2'b01};
		if (t >= trial) begin
			r.rem = 33'(t - trial);
			r.root = {a.root[29:0], 1'b1};
		end else begin
			r.rem = 33'(t);
			r.root = {a.root[29:0], 1'b0};
		end
		r.rad = {a.rad[59:0], 2'b00};
		return r;
	endfunction

	function automatic logic [30:0] cos2_of(logic [15:0] az);
		logic [15:0] ac;
		logic [31:0] sq;
		ac = ({8'd0, az} > LIM) ? 16'(LIM) : az;
		sq = 32'(ac) * 32'(ac);
		return 31'((sq << SHL) >> SHR);
	endfunction

	logic [14:0] roughness_q;
	logic        v_s [1:ST_OUT];
	logic        en;
	logic        en_out;

	assign en_out = !v_s[ST_OUT] || m_tready;
	assign en = en_out || !v_s[ST_DEND];
	assign s_tready = en;
	assign cfg_ready = 1'b1;
	assign m_tvalid = v_s[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roughness_q <= ggx_pkg::ROUGH_RESET;
			for (int k = 1; k <= ST_OUT; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			if (cfg_valid) begin
				roughness_q <= cfg_data;
			end
			if (en) begin
				v_s[1] <= s_tvalid;
				for (int k = 2; k <= ST_DEND; k++) begin
					v_s[k] <= v_s[k-1];
				end
			end
			if (en_out) begin
				v_s[ST_OUT] <= v_s[ST_DEND];
			end
		end
	end

	// stage 1 inputs
	logic signed [15:0] dx, dy, dz, hx, hy, hz;
	logic [15:0] azd, azh;
	logic [14:0] r_eff;

	assign dx = $signed(s_tdata[15:0]);
	assign dy = $signed(s_tdata[31:16]);
	assign dz = $signed(s_tdata[47:32]);
	assign hx = $signed(s_tdata[63:48]);
	assign hy = $signed(s_tdata[79:64]);
	assign hz = $signed(s_tdata[95:80]);
	assign azd = dz[15] ? 16'(~dz + 16'sd1) : dz;
	assign azh = hz[15] ? 16'(~hz + 16'sd1) : hz;
	assign r_eff = (roughness_q == '0) ? 15'd1 : roughness_q;

	logic [31:0]        a2_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic               dzn_s1, dzp_s1;
	logic [30:0]        c2h_s [1:ST_H0-1];
	logic [30:0]        c2w_s [1:ST_W0-1];
	logic [61:0]        mh_s2, mw_s2;
	logic [62:0]        p_s [2:ST_WEND];
	logic [31:0]        m_s3, n_s3;
	logic [63:0]        den_s [ST_W0:ST_WEND];
	sqrt_t              hs_s [ST_H0:ST_WEND];
	sqrt_t              wn_s [ST_W0:ST_WEND];
	sqrt_t              wc_s [ST_W0:ST_WEND];
	flags_t             fl_s [2:ST_DEND];
	logic [76:0]        dnum_s35, pnum_s35;
	logic [63:0]        den_s35;
	logic [45:0]        lnum_s35;
	logic [30:0]        lden_s35;
	logic [46:0]        mnum_s35;
	logic [31:0]        mden_s35;

	logic signed [33:0] dot_c;
	sqrt_t              hs_init, wn_init, wc_init;
	logic [30:0]        root_c, cq_c;
	logic [78:0]        ps_c;

	assign dot_c = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
	assign hs_init = '{rad: {1'b0, c2h_s[ST_H0-1], 30'd0}, rem: '0, root: '0};
	assign wn_init = '{rad: {n_s3, 30'd0}, rem: '0, root: '0};
	assign wc_init = '{rad: {1'b0, c2w_s[ST_W0-1], 30'd0}, rem: '0, root: '0};
	assign root_c = wn_s[ST_WEND].root;
	assign cq_c = wc_s[ST_WEND].root;
	assign ps_c = 79'(p_s[ST_WEND]) * 79'(hs_s[ST_WEND].root[15:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			a2_s1 <= 32'({30'(r_eff) * 30'(r_eff), 2'b00});
			px_s1 <= dx * hx;
			py_s1 <= dy * hy;
			pz_s1 <= dz * hz;
			dzn_s1 <= dz[15];
			dzp_s1 <= !dz[15] && (dz != '0);
			c2h_s[1] <= cos2_of(azh);
			c2w_s[1] <= cos2_of(azd);
			for (int k = 2; k < ST_H0; k++) begin
				c2h_s[k] <= c2h_s[k-1];
			end
			for (int k = 2; k < ST_W0; k++) begin
				c2w_s[k] <= c2w_s[k-1];
			end

			mh_s2 <= 62'(a2_s1 * 62'(c2h_s[1]));
			mw_s2 <= 62'(a2_s1 * 62'(31'h4000_0000 - c2w_s[1]));
			p_s[2] <= 63'(a2_s1 * 63'(ggx_pkg::INV_PI_Q32));
			fl_s[2] <= '{gh: c2h_s[1] == '0, gw: c2w_s[1] == '0,
				back: ((dot_c < 0) && dzp_s1) || ((dot_c > 0) && dzn_s1)};
			for (int k = 3; k <= ST_WEND; k++) begin
				p_s[k] <= p_s[k-1];
			end
			for (int k = 3; k <= ST_DEND; k++) begin
				fl_s[k] <= fl_s[k-1];
			end

			m_s3 <= 32'(33'(mh_s2[61:30]) + 33'h4000_0000 - 33'(c2h_s[2]));
			n_s3 <= 32'(33'(c2w_s[2]) + 33'(mw_s2[61:30]));

			den_s[ST_W0] <= 64'(m_s3) * 64'(m_s3);
			for (int k = ST_W0 + 1; k <= ST_WEND; k++) begin
				den_s[k] <= den_s[k-1];
			end

			wn_s[ST_W0] <= sqrt_step(wn_init);
			wc_s[ST_W0] <= sqrt_step(wc_init);
			for (int k = ST_W0 + 1; k <= ST_WEND; k++) begin
				wn_s[k] <= sqrt_step(wn_s[k-1]);
				wc_s[k] <= sqrt_step(wc_s[k-1]);
			end
			hs_s[ST_H0] <= sqrt_step(hs_init);
			for (int k = ST_H0 + 1; k <= ST_WEND; k++) begin
				hs_s[k] <= sqrt_step(hs_s[k-1]);
			end

			dnum_s35 <= {p_s[ST_WEND], 14'd0};
			pnum_s35 <= ps_c[77:1];
			den_s35 <= den_s[ST_WEND];
			lnum_s35 <= {31'(root_c - cq_c), 15'd0};
			lden_s35 <= cq_c;
			mnum_s35 <= {cq_c, 16'd0};
			mden_s35 <= 32'(root_c) + 32'(cq_c);
		end
	end

	logic [31:0] qd, qp, ql, qm;
	logic        od, op, ol, om;

	ggx_div_pipe #(.NUM_W(77), .DEN_W(64)) u_div_dens (
		.clk(clk), .en(en), .num(dnum_s35), .den(den_s35), .quo(qd), .ovf(od)
	);

	ggx_div_pipe #(.NUM_W(77), .DEN_W(64)) u_div_prob (
		.clk(clk), .en(en), .num(pnum_s35), .den(den_s35), .quo(qp), .ovf(op)
	);

	ggx_div_pipe #(.NUM_W(46), .DEN_W(31)) u_div_lam (
		.clk(clk), .en(en), .num(lnum_s35), .den(lden_s35), .quo(ql), .ovf(ol)
	);

	ggx_div_pipe #(.NUM_W(47), .DEN_W(32)) u_div_mask (
		.clk(clk), .en(en), .num(mnum_s35), .den(mden_s35), .quo(qm), .ovf(om)
	);

	logic [31:0] dens_s69, lam_s69, prob_s69;
	logic [15:0] mask_s69;
	logic        clip_s69;
	flags_t      fl_end;

	assign fl_end = fl_s[ST_DEND];

	always_ff @(posedge clk) begin
		if (en_out) begin
			dens_s69 <= fl_end.gh ? '0 : qd;
			prob_s69 <= fl_end.gh ? '0 : qp;
			lam_s69 <= fl_end.gw ? '0 : ql;
			mask_s69 <= (fl_end.gw || fl_end.back) ? '0 : qm[15:0];
			clip_s69 <= (!fl_end.gh && (od || op)) || (!fl_end.gw && ol);
		end
	end

	assign m_tdata = {prob_s69, lam_s69, mask_s69, dens_s69};
	assign m_tuser = clip_s69;

	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (mask_s69 <= 16'd32768))
		else $error("masking above one");

	a_mask_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[ST_DEND] && !fl_end.gw) |-> (!om && (qm <= 32'd32768)))
		else $error("masking quotient out of range");

	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (dens_s69 == '1 || lam_s69 == '1 || prob_s69 == '1))
		else $error("clip flag without saturated field");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[ST_OUT] && !m_tready && v_s[ST_DEND]) |-> !s_tready)
		else $error("input taken while pipe is blocked");

	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[ST_DEND] && !en) |=> v_s[ST_DEND])
		else $error("last stage item dropped during stall");

endmodule

`default_nettype wire

/* bench/ggx_microfacet_eval_core_tb.sv */
// ----------------------------------------------------------------------------
// ggx_microfacet_eval_core_tb
// Self-checking bench for the GGX evaluator: a table of directed pairs, then
// random direction pairs under several roughness settings, each result compared
// field by field with a bit-true fixed-point predictor or a typed row's stored result.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_microfacet_eval_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CFB = 15;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic        clipped;
		logic [31:0] probability;
		logic [31:0] lambda_term;
		logic [15:0] masking;
		logic [31:0] density;
	} ggx_res_t;

	typedef struct {
		logic signed [15:0] d [3];
		logic signed [15:0] h [3];
		bit                 typed;
		ggx_res_t           res;
	} vec_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic         m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [14:0]  cfg_data;

	logic [14:0] alpha_reg;
	ggx_res_t    pending_q [$];
	int          errors;
	int          idle_cycles;
	int          cyc;

	ggx_microfacet_eval_core #(.COMPONENT_FRACTION_BITS(CFB)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] cos_sq(logic signed [15:0] z);
		logic [63:0] a;
		a = z < 0 ? 64'(-32'(z)) : 64'(z);
		if (a > (64'd1 << CFB)) a = 64'd1 << CFB;
		return ((a * a) << 16) >> (2 * CFB - 14);
	endfunction

	function automatic logic [31:0] quot_sat(logic [127:0] num, logic [63:0] den,
			inout bit clip);
		logic [127:0] q;
		q = num / {64'd0, den};
		if (q > {64'd0, MAX32}) begin
			clip = 1;
			return 32'hFFFF_FFFF;
		end
		return q[31:0];
	endfunction

	function automatic ggx_res_t ggx_eval(logic signed [15:0] d [3],
			logic signed [15:0] h [3], logic [14:0] alpha);
		ggx_res_t    o;
		longint      dotp;
		logic [63:0] r, a2, c2h, c2w, m, den, p, n, root, cq, lq;
		bit          clip, back;
		o = '0;
		clip = 0;
		dotp = longint'(d[0]) * h[0] + longint'(d[1]) * h[1] + longint'(d[2]) * h[2];
		r = alpha != 0 ? 64'(alpha) : 64'd1;
		a2 = (r * r) << 2;
		c2h = cos_sq(h[2]);
		c2w = cos_sq(d[2]);
		if (c2h != 0) begin
			m = ((a2 * c2h) >> 30) + ONE_Q30 - c2h;
			den = m * m;
			p = a2 * 64'(ggx_pkg::INV_PI_Q32);
			o.density = quot_sat({64'd0, p} << 14, den, clip);
			o.probability = quot_sat(({64'd0, p} * {64'd0, isqrt(c2h)}) >> 1, den, clip);
		end
		if (c2w != 0) begin
			n = c2w + ((a2 * (ONE_Q30 - c2w)) >> 30);
			root = isqrt(n << 30);
			cq = isqrt(c2w << 30);
			back = (dotp < 0 && d[2] > 0) || (dotp > 0 && d[2] < 0);
			lq = ((root - cq) << 15) / cq;
			if (lq > MAX32) begin
				clip = 1;
				lq = MAX32;
			end
			o.lambda_term = lq[31:0];
			o.masking = back ? 16'd0 : 16'(((cq << 16) / (cq + root)));
		end
		o.clipped = clip;
		return o;
	endfunction

	// result check
	always @(posedge clk) begin
		ggx_res_t got, want;
		if (m_tvalid && m_tready) begin
			got.density = m_tdata[31:0];
			got.masking = m_tdata[47:32];
			got.lambda_term = m_tdata[79:48];
			got.probability = m_tdata[111:80];
			got.clipped = m_tuser;
			if (pending_q.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (got.density !== want.density) begin
					$error("density exp %h got %h", want.density, got.density);
					errors++;
				end
				if (got.masking !== want.masking) begin
					$error("masking exp %h got %h", want.masking, got.masking);
					errors++;
				end
				if (got.lambda_term !== want.lambda_term) begin
					$error("lambda_term exp %h got %h", want.lambda_term, got.lambda_term);
					errors++;
				end
				if (got.probability !== want.probability) begin
					$error("probability exp %h got %h", want.probability, got.probability);
					errors++;
				end
				if (got.clipped !== want.clipped) begin
					$error("clipped exp %b got %b", want.clipped, got.clipped);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		cyc++;
		case ((cyc / 300) % 3)
			0: begin
				m_tready = 1'b1;
			end
			1: begin
				m_tready = ($urandom_range(0, 99) >= 35);
			end
			default: begin
				m_tready = (cyc % 9) >= 4;
			end
		endcase
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("ggx_microfacet_eval_core_tb: FAIL");
			$finish;
		end
	end

	int burst_left;

	task automatic send_pair(logic signed [15:0] d [3], logic signed [15:0] h [3],
			bit typed, ggx_res_t res);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tdata = {h[2], h[1], h[0], d[2], d[1], d[0]};
		do @(posedge clk); while (!s_tready);
		pending_q.push_back(typed ? res : ggx_eval(d, h, alpha_reg));
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (ggx_pkg::DIV_LAT + 40) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_alpha(logic [14:0] v);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		alpha_reg = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return -16'sd32768;
			2: return 16'(signed'($urandom_range(0, 6)) - 3);
			3: return 16'($urandom_range(0, 400));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_pairs(int count);
		logic signed [15:0] d [3];
		logic signed [15:0] h [3];
		for (int i = 0; i < count; i++) begin
			foreach (d[k]) d[k] = rand_comp();
			foreach (h[k]) h[k] = rand_comp();
			send_pair(d, h, 0, '0);
		end
	endtask

	vec_row_t dir_table [$];

	task automatic add_row(int dx, int dy, int dz, int hx, int hy, int hz,
			bit typed = 0);
		vec_row_t row;
		row.d = '{16'(dx), 16'(dy), 16'(dz)};
		row.h = '{16'(hx), 16'(hy), 16'(hz)};
		row.typed = typed;
		row.res = '0;
		dir_table.push_back(row);
	endtask

	initial begin
		logic [14:0] alpha_set [$];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		cyc = 0;
		burst_left = 0;
		alpha_reg = ggx_pkg::ROUGH_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// grazing on both sides: everything zero
		add_row(32767, 0, 0, 0, 32767, 0, 1);
		add_row(0, 0, 0, 0, 0, 0, 1);
		add_row(0, 0, 32767, 0, 0, 32767);
		add_row(0, 0, -32768, 0, 0, -32768);
		add_row(-32768, -32768, -32768, 32767, 32767, 32767);
		add_row(32767, 0, 1, -32768, 0, 100);
		add_row(-32768, 0, -1, -32768, 0, 100);
		add_row(23170, 0, 23170, -23170, 0, 23170);
		add_row(0, 0, 1, 0, 0, 1);
		add_row(0, 0, -1, 0, 0, -1);
		add_row(100, 200, 32767, 5, -7, 1);
		add_row(-1, 1, 16384, 1, -1, -16384);
		add_row(30000, -12000, -5000, 12000, 30000, 2);
		foreach (dir_table[i])
			send_pair(dir_table[i].d, dir_table[i].h, dir_table[i].typed, dir_table[i].res);
		random_pairs(150);
		drain();

		alpha_set = '{15'd1, 15'd32767, 15'd0, 15'h5555, 15'h2AAA, 15'd16384};
		for (int i = 0; i < 3; i++) alpha_set.push_back(15'($urandom_range(1, 32767)));
		foreach (alpha_set[i]) begin
			write_alpha(alpha_set[i]);
			random_pairs(110);
			drain();
		end

		if (errors == 0)
			$display("ggx_microfacet_eval_core_tb: PASS");
		else
			$display("ggx_microfacet_eval_core_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

/* ggx_microfacet_eval_core.f */
design/ggx_pkg.sv
design/ggx_div_pipe.sv
design/ggx_microfacet_eval_core.sv
bench/ggx_microfacet_eval_core_tb.sv
